@@ rtl/core/clti_pkg.sv @@
// ----------------------------------------------------------------------------
// clti_pkg: types and constants of the C literal to integer converter
// Holds the beat structs of both channels, the parse phase and status codes,
// the character codes the parser looks for and the small decode functions.
// ----------------------------------------------------------------------------
package clti_pkg;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } clti_req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [2:0]         status;
   } clti_rsp_type;

   typedef enum logic [2:0] {
      PH_PREFIX  = 3'd0,
      PH_SIGNED  = 3'd1,
      PH_ZERO    = 3'd2,
      PH_HEXWAIT = 3'd3,
      PH_DIGITS  = 3'd4,
      PH_CHAR    = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MULTI    = 3'd1,
      ST_STRING   = 3'd2,
      ST_FLOAT    = 3'd3,
      ST_SUFFIX   = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      BASE_OCT = 2'd0,
      BASE_DEC = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_ESCAPE = 2'd1,
      POS_CLOSE  = 2'd2
   } char_pos_type;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_ONE       = 8'h31;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_UP_F      = 8'h46;
   localparam logic [7:0] CH_UP_L      = 8'h4C;
   localparam logic [7:0] CH_UP_U      = 8'h55;
   localparam logic [7:0] CH_UP_X      = 8'h58;
   localparam logic [7:0] CH_LO_A      = 8'h61;
   localparam logic [7:0] CH_LO_B      = 8'h62;
   localparam logic [7:0] CH_LO_F      = 8'h66;
   localparam logic [7:0] CH_LO_L      = 8'h6C;
   localparam logic [7:0] CH_LO_N      = 8'h6E;
   localparam logic [7:0] CH_LO_R      = 8'h72;
   localparam logic [7:0] CH_LO_T      = 8'h74;
   localparam logic [7:0] CH_LO_U      = 8'h75;
   localparam logic [7:0] CH_LO_V      = 8'h76;
   localparam logic [7:0] CH_LO_X      = 8'h78;

   localparam logic [7:0] ESC_BELL     = 8'd7;
   localparam logic [7:0] ESC_BACK     = 8'd8;
   localparam logic [7:0] ESC_FEED     = 8'd12;
   localparam logic [7:0] ESC_NEWLINE  = 8'd10;
   localparam logic [7:0] ESC_RETURN   = 8'd13;
   localparam logic [7:0] ESC_TAB      = 8'd9;
   localparam logic [7:0] ESC_VTAB     = 8'd11;

   localparam logic [68:0] LIMIT_POS = 69'h0_7FFF_FFFF_FFFF_FFFF;
   localparam logic [68:0] LIMIT_NEG = 69'h0_8000_0000_0000_0000;

   // Digit value of a byte in any base up to 16; 16 means not a digit.
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd16;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 5'(c - CH_ZERO);
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         d = 5'(c - CH_LO_A) + 5'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         d = 5'(c - CH_UP_A) + 5'd10;
      end
      return d;
   endfunction

   function automatic logic [4:0] base_value(input base_type b);
      logic [4:0] v;
      unique case (b)
         BASE_OCT: v = 5'd8;
         BASE_HEX: v = 5'd16;
         default:  v = 5'd10;
      endcase
      return v;
   endfunction

   // Accumulator times base plus digit, wide enough never to wrap.
   function automatic logic [68:0] shift_add(input logic [63:0] acc, input base_type b,
                                             input logic [4:0] d);
      logic [68:0] a;
      logic [68:0] p;
      a = {5'd0, acc};
      unique case (b)
         BASE_OCT: p = a << 3;
         BASE_HEX: p = a << 4;
         default:  p = (a << 3) + (a << 1);
      endcase
      return p + {64'd0, d};
   endfunction

   function automatic logic [7:0] escape_char(input logic [7:0] c);
      logic [7:0] v;
      unique case (c)
         CH_ZERO: v = CH_NUL;
         CH_LO_A: v = ESC_BELL;
         CH_LO_B: v = ESC_BACK;
         CH_LO_F: v = ESC_FEED;
         CH_LO_N: v = ESC_NEWLINE;
         CH_LO_R: v = ESC_RETURN;
         CH_LO_T: v = ESC_TAB;
         CH_LO_V: v = ESC_VTAB;
         default: v = c;
      endcase
      return v;
   endfunction

   // Status after the first byte that is not a digit; overflow is kept.
   function automatic status_type decide(input logic [7:0] c, input status_type cur);
      status_type s;
      if (cur == ST_OVERFLOW) begin
         s = cur;
      end else if (c == CH_DOT) begin
         s = ST_FLOAT;
      end else if (c == CH_LO_L || c == CH_UP_L || c == CH_LO_U || c == CH_UP_U
                   || c == CH_NUL) begin
         s = ST_OK;
      end else begin
         s = ST_SUFFIX;
      end
      return s;
   endfunction

endpackage

@@ rtl/core/c_literal_to_integer.sv @@
// ----------------------------------------------------------------------------
// c_literal_to_integer: C integer and character constant parser
// Takes a literal one byte per beat and returns its 64-bit value and a
// status once the beat marked as the last byte has been taken.
// ----------------------------------------------------------------------------
//
//   channel  direction  beat contents               result beats
//   req      in         char_byte, last_byte        one per byte
//   rsp      out        value, status               one per literal
//
// A byte is taken in every cycle unless a last byte is held by a result stall; the
// parse state register holds the only loop, one byte step with a 69-bit shift-add and
// compare per cycle. The result of a literal is registered in the fin stage and then
// in the rsp stage. Stalls travel back through the three stages in the same cycle.
// Reset returns the parser to the start of a literal and empties all stages.
module c_literal_to_integer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  clti_pkg::clti_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output clti_pkg::clti_rsp_type rsp_payload
);
   import clti_pkg::*;

   logic         in_valid_ff;
   clti_req_type in_beat_ff;

   phase_type    phase_ff,  phase_in;
   logic [63:0]  acc_ff,    acc_in;
   base_type     base_ff,   base_in;
   logic         neg_ff,    neg_in;
   status_type   status_ff, status_in;
   char_pos_type pos_ff,    pos_in;

   logic         fin_valid_ff;
   logic [63:0]  fin_acc_ff;
   logic         fin_neg_ff;
   status_type   fin_status_ff, fin_status_in;

   logic         rsp_valid_ff;
   clti_rsp_type rsp_ff;

   logic         rsp_open;
   logic         fin_move;
   logic         fin_open;
   logic         in_move;
   logic         in_open;

   logic [7:0]   c;
   logic [4:0]   d;
   logic [7:0]   esc_char;
   logic [68:0]  next_acc;
   logic         ovf;

   phase_type    step_phase;
   logic [63:0]  step_acc;
   base_type     step_base;
   logic         step_neg;
   status_type   step_status;
   char_pos_type step_pos;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign fin_move  = fin_valid_ff && rsp_open;
   assign fin_open  = !fin_valid_ff || rsp_open;
   assign in_move   = in_valid_ff && (!in_beat_ff.last_byte || fin_open);
   assign in_open   = !in_valid_ff || in_move;
   assign req_stall = !in_open;

   assign c        = in_beat_ff.char_byte;
   assign d        = digit_of(c);
   assign esc_char = escape_char(c);
   assign next_acc = shift_add(acc_ff, base_ff, d);
   assign ovf      = next_acc > (neg_ff ? LIMIT_NEG : LIMIT_POS);

   always_comb begin
      step_phase  = phase_ff;
      step_acc    = acc_ff;
      step_base   = base_ff;
      step_neg    = neg_ff;
      step_status = status_ff;
      step_pos    = pos_ff;
      unique case (phase_ff)
         PH_PREFIX, PH_SIGNED: begin
            priority if (phase_ff == PH_PREFIX
                         && (c == CH_LO_U || c == CH_UP_U || c == CH_UP_L)) begin
               step_phase = PH_PREFIX;
            end else if (phase_ff == PH_PREFIX && c == CH_NUL) begin
               step_acc    = 64'd0;
               step_status = ST_OK;
               step_phase  = PH_DONE;
            end else if (phase_ff == PH_PREFIX && c == CH_QUOTE) begin
               step_pos   = POS_FIRST;
               step_phase = PH_CHAR;
            end else if (phase_ff == PH_PREFIX && c == CH_DQUOTE) begin
               step_status = ST_STRING;
               step_phase  = PH_DONE;
            end else if (phase_ff == PH_PREFIX && (c == CH_PLUS || c == CH_MINUS)) begin
               step_neg   = (c == CH_MINUS);
               step_phase = PH_SIGNED;
            end else if (c == CH_ZERO) begin
               step_acc   = 64'd0;
               step_phase = PH_ZERO;
            end else if (c >= CH_ONE && c <= CH_NINE) begin
               step_base  = BASE_DEC;
               step_acc   = {59'd0, d};
               step_phase = PH_DIGITS;
            end else if (phase_ff == PH_SIGNED) begin
               step_status = ST_SUFFIX;
               step_phase  = PH_DONE;
            end else begin
               step_status = decide(c, status_ff);
               step_phase  = PH_DONE;
            end
         end
         PH_ZERO: begin
            priority if (c == CH_LO_X || c == CH_UP_X) begin
               step_base  = BASE_HEX;
               step_phase = PH_HEXWAIT;
            end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
               step_base  = BASE_OCT;
               step_acc   = {59'd0, d};
               step_phase = PH_DIGITS;
            end else begin
               step_status = decide(c, status_ff);
               step_phase  = PH_DONE;
            end
         end
         PH_HEXWAIT: begin
            if (d < 5'd16) begin
               step_acc   = {59'd0, d};
               step_phase = PH_DIGITS;
            end else begin
               step_acc    = 64'd0;
               step_status = ST_SUFFIX;
               step_phase  = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (d < base_value(base_ff)) begin
               if (status_ff != ST_OVERFLOW) begin
                  if (ovf) begin
                     step_status = ST_OVERFLOW;
                  end else begin
                     step_acc = next_acc[63:0];
                  end
               end
            end else begin
               step_status = decide(c, status_ff);
               step_phase  = PH_DONE;
            end
         end
         PH_CHAR: begin
            unique case (pos_ff)
               POS_FIRST: begin
                  if (c == CH_BACKSLASH) begin
                     step_pos = POS_ESCAPE;
                  end else begin
                     step_acc = {{56{c[7]}}, c};
                     step_pos = POS_CLOSE;
                  end
               end
               POS_ESCAPE: begin
                  step_acc = {{56{esc_char[7]}}, esc_char};
                  step_pos = POS_CLOSE;
               end
               default: begin
                  step_status = (c == CH_QUOTE) ? ST_OK : ST_MULTI;
                  step_phase  = PH_DONE;
               end
            endcase
         end
         default: begin
            step_phase = PH_DONE;
         end
      endcase
   end

   // End of text: the zero bytes past the last one settle the status.
   always_comb begin
      unique case (step_phase)
         PH_PREFIX:             fin_status_in = ST_OK;
         PH_SIGNED, PH_HEXWAIT: fin_status_in = ST_SUFFIX;
         PH_CHAR:               fin_status_in = ST_MULTI;
         default:               fin_status_in = step_status;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      neg_in    = neg_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      if (in_move) begin
         if (in_beat_ff.last_byte) begin
            phase_in  = PH_PREFIX;
            acc_in    = 64'd0;
            base_in   = BASE_DEC;
            neg_in    = 1'b0;
            status_in = ST_OK;
            pos_in    = POS_FIRST;
         end else begin
            phase_in  = step_phase;
            acc_in    = step_acc;
            base_in   = step_base;
            neg_in    = step_neg;
            status_in = step_status;
            pos_in    = step_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_PREFIX;
         acc_ff       <= 64'd0;
         base_ff      <= BASE_DEC;
         neg_ff       <= 1'b0;
         status_ff    <= ST_OK;
         pos_ff       <= POS_FIRST;
      end else begin
         if (in_open) begin
            in_valid_ff <= req_valid;
         end
         if (fin_open) begin
            fin_valid_ff <= in_move && in_beat_ff.last_byte;
         end
         if (rsp_open) begin
            rsp_valid_ff <= fin_valid_ff;
         end
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         base_ff   <= base_in;
         neg_ff    <= neg_in;
         status_ff <= status_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open && req_valid) begin
         in_beat_ff <= req_payload;
      end
      if (fin_open && in_move && in_beat_ff.last_byte) begin
         fin_acc_ff    <= step_acc;
         fin_neg_ff    <= step_neg;
         fin_status_ff <= fin_status_in;
      end
      if (fin_move) begin
         rsp_ff.status <= fin_status_ff;
         if (fin_status_ff != ST_OK) begin
            rsp_ff.value <= 64'sd0;
         end else if (fin_neg_ff) begin
            rsp_ff.value <= $signed(64'd0 - fin_acc_ff);
         end else begin
            rsp_ff.value <= $signed(fin_acc_ff);
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sim/clti_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clti_checker: result checker for the C literal to integer converter
// Watches both channels and runs its own byte-by-byte literal parser on every
// accepted request beat. Each literal end queues the expected value and
// status. Each accepted result beat is compared with the oldest entry.
// ----------------------------------------------------------------------------
module clti_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  clti_pkg::clti_req_type req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  clti_pkg::clti_rsp_type rsp_payload,
   output int                     failures,
   output int                     pending,
   output int                     results_checked
);
   import clti_pkg::*;

   phase_type    phase;
   logic [63:0]  acc;
   logic [4:0]   radix;
   logic         minus;
   status_type   stat;
   char_pos_type cpos;
   clti_rsp_type expected_q[$];

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return 5'd16;
   endfunction

   function automatic logic [63:0] char_value(input logic [7:0] c);
      return {{56{c[7]}}, c};
   endfunction

   function automatic logic [63:0] escaped_value(input logic [7:0] c);
      logic [63:0] v;
      case (c)
         "0": v = 64'd0;
         "a": v = 64'd7;
         "b": v = 64'd8;
         "f": v = 64'd12;
         "n": v = 64'd10;
         "r": v = 64'd13;
         "t": v = 64'd9;
         "v": v = 64'd11;
         default: v = char_value(c);
      endcase
      return v;
   endfunction

   task automatic clear_literal();
      phase = PH_PREFIX;
      acc = 64'd0;
      radix = 5'd10;
      minus = 1'b0;
      stat = ST_OK;
      cpos = POS_FIRST;
   endtask

   task automatic settle(input logic [7:0] c);
      if (stat != ST_OVERFLOW) begin
         if (c == ".") begin
            stat = ST_FLOAT;
         end else if (c == "l" || c == "L" || c == "u" || c == "U" || c == CH_NUL) begin
            stat = ST_OK;
         end else begin
            stat = ST_SUFFIX;
         end
      end
      phase = PH_DONE;
   endtask

   task automatic add_digit(input logic [4:0] d);
      logic [63:0] lim;
      lim = minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (stat != ST_OVERFLOW) begin
         if (acc > (lim - 64'(d)) / 64'(radix)) begin
            stat = ST_OVERFLOW;
         end else begin
            acc = acc * 64'(radix) + 64'(d);
         end
      end
   endtask

   task automatic open_number(input logic [7:0] c, input logic after_sign);
      if (c == "0") begin
         acc = 64'd0;
         phase = PH_ZERO;
      end else if (c >= "1" && c <= "9") begin
         radix = 5'd10;
         acc = 64'(c - "0");
         phase = PH_DIGITS;
      end else if (after_sign) begin
         stat = ST_SUFFIX;
         phase = PH_DONE;
      end else begin
         settle(c);
      end
   endtask

   task automatic take(input logic [7:0] c);
      logic [4:0] d;
      d = digit_value(c);
      case (phase)
         PH_PREFIX: begin
            if (c == CH_NUL) begin
               acc = 64'd0;
               stat = ST_OK;
               phase = PH_DONE;
            end else if (c == "'") begin
               cpos = POS_FIRST;
               phase = PH_CHAR;
            end else if (c == "\"") begin
               stat = ST_STRING;
               phase = PH_DONE;
            end else if (c == "+" || c == "-") begin
               minus = (c == "-");
               phase = PH_SIGNED;
            end else if (c != "u" && c != "U" && c != "L") begin
               open_number(c, 1'b0);
            end
         end
         PH_SIGNED: open_number(c, 1'b1);
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               radix = 5'd16;
               phase = PH_HEXWAIT;
            end else if (c >= "0" && c <= "7") begin
               radix = 5'd8;
               acc = 64'(c - "0");
               phase = PH_DIGITS;
            end else begin
               settle(c);
            end
         end
         PH_HEXWAIT: begin
            if (d < 5'd16) begin
               acc = 64'(d);
               phase = PH_DIGITS;
            end else begin
               acc = 64'd0;
               stat = ST_SUFFIX;
               phase = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (d < radix) begin
               add_digit(d);
            end else begin
               settle(c);
            end
         end
         PH_CHAR: begin
            case (cpos)
               POS_FIRST: begin
                  if (c == "\\") begin
                     cpos = POS_ESCAPE;
                  end else begin
                     acc = char_value(c);
                     cpos = POS_CLOSE;
                  end
               end
               POS_ESCAPE: begin
                  acc = escaped_value(c);
                  cpos = POS_CLOSE;
               end
               default: begin
                  stat = (c == "'") ? ST_OK : ST_MULTI;
                  phase = PH_DONE;
               end
            endcase
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      clti_rsp_type want;
      if (reset) begin
         clear_literal();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               failures++;
               $display("%0t: result beat with none expected, got value %0d status %0d",
                        $time, rsp_payload.value, rsp_payload.status);
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (rsp_payload.value !== want.value) begin
                  failures++;
                  $display("%0t: value mismatch, expected %0d got %0d",
                           $time, want.value, rsp_payload.value);
               end
               if (rsp_payload.status !== want.status) begin
                  failures++;
                  $display("%0t: status mismatch, expected %0d got %0d",
                           $time, want.status, rsp_payload.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            take(req_payload.char_byte);
            if (req_payload.last_byte) begin
               for (int i = 0; i < 4 && phase != PH_DONE; i++) take(CH_NUL);
               want.status = stat;
               want.value = 64'sd0;
               if (stat == ST_OK) begin
                  want.value = acc;
                  if (phase == PH_DONE && minus) want.value = -acc;
               end
               expected_q.push_back(want);
               clear_literal();
            end
         end
         pending = expected_q.size();
      end
   end

endmodule

@@ sim/tb_c_literal_to_integer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_literal_to_integer: testbench of the C literal to integer converter
// Sends a directed set of literals covering limits, bases, suffixes, character
// escapes and error cases, then random literals, mostly well formed, with
// random gaps and result stalls. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_c_literal_to_integer;
   import clti_pkg::*;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   clti_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   clti_rsp_type rsp_payload;

   logic         calm = 1'b0;
   int           sent_bytes = 0;
   int           failures;
   int           pending;
   int           results_checked;
   logic [7:0]   text_q[$];
   string        hex_chars = "0123456789abcdefABCDEF";
   string        esc_chars = "0abfnrtv\\'\"q";

   c_literal_to_integer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   clti_checker check_unit (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[c_literal_to_integer] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 29);
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic send_literal();
      for (int i = 0; i < text_q.size(); i++) begin
         while (!calm && $urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_payload <= '{char_byte: text_q[i], last_byte: (i == text_q.size() - 1)};
         req_valid <= 1'b1;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         sent_bytes++;
      end
      text_q.delete();
   endtask

   task automatic add_tail();
      case ($urandom_range(11))
         0: add_text("u");
         1: add_text("L");
         2: add_text("l");
         3: add_text("U");
         4: add_text(".5");
         5: text_q.push_back(8'($urandom_range(255)));
         6: add_text("ULL");
         7: begin
            text_q.push_back(CH_NUL);
            text_q.push_back(8'($urandom_range(255)));
         end
         default: ;
      endcase
   endtask

   task automatic make_random_literal();
      int kind;
      int n;
      kind = $urandom_range(99);
      if ($urandom_range(9) == 0) add_text($urandom_range(1) ? "L" : "u");
      if (kind < 30) begin
         case ($urandom_range(5))
            0: add_text("-");
            1: add_text("+");
            default: ;
         endcase
         if ($urandom_range(7) == 0) begin
            add_text("92233720368547758");
            text_q.push_back(hex_chars[$urandom_range(9)]);
            if ($urandom_range(1)) text_q.push_back(hex_chars[$urandom_range(9)]);
         end else begin
            n = ($urandom_range(3) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
            text_q.push_back(hex_chars[$urandom_range(1, 9)]);
            for (int i = 1; i < n; i++) text_q.push_back(hex_chars[$urandom_range(9)]);
         end
         add_tail();
      end else if (kind < 45) begin
         add_text("0");
         n = ($urandom_range(3) == 0) ? $urandom_range(18, 23) : $urandom_range(0, 5);
         for (int i = 0; i < n; i++) text_q.push_back(hex_chars[$urandom_range(7)]);
         if ($urandom_range(7) == 0) add_text($urandom_range(1) ? "8" : "9");
         add_tail();
      end else if (kind < 60) begin
         add_text($urandom_range(1) ? "0x" : "0X");
         n = ($urandom_range(3) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 6);
         for (int i = 0; i < n; i++) text_q.push_back(hex_chars[$urandom_range(21)]);
         add_tail();
      end else if (kind < 80) begin
         add_text("'");
         if ($urandom_range(1)) begin
            text_q.push_back(8'($urandom_range(255)));
         end else begin
            add_text("\\");
            if ($urandom_range(3) != 0) begin
               text_q.push_back(esc_chars[$urandom_range(esc_chars.len() - 1)]);
            end else begin
               text_q.push_back(8'($urandom_range(255)));
            end
         end
         if ($urandom_range(9) != 0) begin
            add_text("'");
         end else begin
            text_q.push_back(8'($urandom_range(255)));
         end
         if ($urandom_range(7) == 0) text_q.push_back(8'($urandom_range(255)));
      end else if (kind < 88) begin
         add_text("\"");
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_text("0");                        send_literal();
      add_text("9223372036854775807");      send_literal();
      add_text("-9223372036854775808");     send_literal();
      add_text("9223372036854775808");      send_literal();
      add_text("-9223372036854775809");     send_literal();
      add_text("0xFFFFFFFFFFFFFFFFFF");     send_literal();
      add_text("0X7fffffffffffffffUL");     send_literal();
      add_text("+0777l");                   send_literal();
      add_text("08");                       send_literal();
      add_text("0x");                       send_literal();
      add_text("0xg1");                     send_literal();
      add_text("1.5");                      send_literal();
      add_text("12ab");                     send_literal();
      add_text("-");                        send_literal();
      add_text("+x");                       send_literal();
      add_text("uL'a'");                    send_literal();
      add_text("'\\n'");                    send_literal();
      add_text("'\\q'");                    send_literal();
      add_text("'ab'");                     send_literal();
      add_text("\"str\"");                  send_literal();
      add_text("U");                        send_literal();
      text_q.push_back(CH_NUL);             send_literal();
      add_text("12");
      text_q.push_back(CH_NUL);
      add_text("99");                       send_literal();
      add_text("'");
      text_q.push_back(8'hFF);
      add_text("'");                        send_literal();
      add_text("'");                        send_literal();

      while (sent_bytes < 1200) begin
         calm <= (sent_bytes >= 500 && sent_bytes < 750);
         make_random_literal();
         send_literal();
      end
      calm <= 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d literal bytes and compared %0d results over numbers in all bases,",
               sent_bytes, results_checked);
      $display("character constants, strings, suffix and overflow errors and raw noise.");
      if (failures == 0) begin
         $display("[c_literal_to_integer] OK");
      end else begin
         $display("[c_literal_to_integer] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/clti_pkg.sv
rtl/core/c_literal_to_integer.sv
sim/clti_checker.sv
sim/tb_c_literal_to_integer.sv
